FILE: rtl/sfdp_pkg.sv
// shared constants, types and command struct for the sfdp basic table decoder
package sfdp_pkg;

    localparam int MAX_WORDS = 16;
    localparam int COUNT_W   = $clog2(MAX_WORDS + 1);

    typedef logic [COUNT_W-1:0] count_t;

    // table word positions that are kept
    localparam int IDX_FIRST   = 0;
    localparam int IDX_DENSITY = 1;
    localparam int IDX_ERASE_L = 7;
    localparam int IDX_ERASE_H = 8;
    localparam int IDX_PAGE    = 10;

    // table lengths that switch the decode
    localparam int LEN_ERASE_TABLE = 9;
    localparam int LEN_PAGE_WORD   = 11;

    localparam logic [23:0] CAP_MAX       = 24'hffffff;
    localparam logic [7:0]  LEGACY_ERASE  = 8'd12;
    localparam logic [3:0]  PAGE_LOG2_64  = 4'd6;
    localparam logic [3:0]  PAGE_LOG2_1   = 4'd0;
    localparam logic [1:0]  LEGACY_4K_OK  = 2'b01;

    // decode status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_4K    = 2'd1;
    localparam logic [1:0] STATUS_NO_ERASE = 2'd2;

    typedef struct packed {
        logic capture;      // store the incoming word
        logic load_result;  // decode stored words into the output register, then clear
    } dp_cmd_t;

endpackage

FILE: rtl/sfdp_datapath.sv
// word store, decode logic and result register
module sfdp_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [31:0]           table_word,
    input  sfdp_pkg::dp_cmd_t     cmd,
    output logic [23:0]           capacity_bytes,
    output logic [3:0]            page_size_log2,
    output logic [7:0]            erase_size_log2,
    output logic [7:0]            erase_opcode,
    output logic [1:0]            decode_status
);

    sfdp_pkg::count_t word_count_reg, word_count_next;
    logic [31:0] first_word_reg, first_word_next;
    logic [31:0] density_word_reg, density_word_next;
    logic [31:0] erase_low_reg, erase_low_next;
    logic [31:0] erase_high_reg, erase_high_next;
    logic [31:0] page_word_reg, page_word_next;

    logic [23:0] cap_reg;
    logic [3:0]  page_reg;
    logic [7:0]  esz_reg;
    logic [7:0]  eop_reg;
    logic [1:0]  status_reg;

    logic [23:0] cap_calc;
    logic [3:0]  page_calc;
    logic [7:0]  esz_calc;
    logic [7:0]  eop_calc;
    logic [1:0]  status_calc;

    // word capture
    always_comb
    begin
        word_count_next   = word_count_reg;
        first_word_next   = first_word_reg;
        density_word_next = density_word_reg;
        erase_low_next    = erase_low_reg;
        erase_high_next   = erase_high_reg;
        page_word_next    = page_word_reg;
        if (cmd.load_result)
        begin
            word_count_next   = '0;
            first_word_next   = '0;
            density_word_next = '0;
            erase_low_next    = '0;
            erase_high_next   = '0;
            page_word_next    = '0;
        end
        else if (cmd.capture && (word_count_reg < sfdp_pkg::count_t'(sfdp_pkg::MAX_WORDS)))
        begin
            priority if (word_count_reg == sfdp_pkg::count_t'(sfdp_pkg::IDX_FIRST))
                first_word_next = table_word;
            else if (word_count_reg == sfdp_pkg::count_t'(sfdp_pkg::IDX_DENSITY))
                density_word_next = table_word;
            else if (word_count_reg == sfdp_pkg::count_t'(sfdp_pkg::IDX_ERASE_L))
                erase_low_next = table_word;
            else if (word_count_reg == sfdp_pkg::count_t'(sfdp_pkg::IDX_ERASE_H))
                erase_high_next = table_word;
            else if (word_count_reg == sfdp_pkg::count_t'(sfdp_pkg::IDX_PAGE))
                page_word_next = table_word;
            else
                first_word_next = first_word_reg;
            word_count_next = word_count_reg + 1'b1;
        end
    end

    // capacity
    logic [30:0] dens_low;
    logic [31:0] bits_plus_one;
    logic [28:0] bytes_lin;
    logic [4:0]  exp_shift;

    always_comb
    begin
        dens_low      = density_word_reg[30:0];
        bits_plus_one = {1'b0, dens_low} + 32'd1;
        bytes_lin     = bits_plus_one[31:3];
        exp_shift     = dens_low[4:0] - 5'd3;
        if (density_word_reg[31])
        begin
            priority if (dens_low < 31'd3)
                cap_calc = '0;
            else if (dens_low >= 31'd27)
                cap_calc = sfdp_pkg::CAP_MAX;
            else
                cap_calc = 24'd1 << exp_shift;
        end
        else if (bytes_lin > {5'd0, sfdp_pkg::CAP_MAX})
            cap_calc = sfdp_pkg::CAP_MAX;
        else
            cap_calc = bytes_lin[23:0];
    end

    // page size and erase choice
    logic [15:0] entry [4];
    logic        found;

    always_comb
    begin
        entry[0] = erase_low_reg[31:16];
        entry[1] = erase_low_reg[15:0];
        entry[2] = erase_high_reg[31:16];
        entry[3] = erase_high_reg[15:0];

        if (word_count_reg >= sfdp_pkg::count_t'(sfdp_pkg::LEN_PAGE_WORD))
            page_calc = page_word_reg[7:4];
        else if (first_word_reg[2])
            page_calc = sfdp_pkg::PAGE_LOG2_64;
        else
            page_calc = sfdp_pkg::PAGE_LOG2_1;

        esz_calc    = '0;
        eop_calc    = '0;
        status_calc = sfdp_pkg::STATUS_OK;
        found       = 1'b0;
        if (word_count_reg < sfdp_pkg::count_t'(sfdp_pkg::LEN_ERASE_TABLE))
        begin
            if (first_word_reg[1:0] == sfdp_pkg::LEGACY_4K_OK)
            begin
                esz_calc = sfdp_pkg::LEGACY_ERASE;
                eop_calc = first_word_reg[15:8];
            end
            else
                status_calc = sfdp_pkg::STATUS_NO_4K;
        end
        else
        begin
            // earliest entry wins on equal size
            for (int i = 0; i < 4; i++)
            begin
                if ((entry[i][7:0] != 8'd0) && (!found || (entry[i][7:0] < esz_calc)))
                begin
                    esz_calc = entry[i][7:0];
                    eop_calc = entry[i][15:8];
                    found    = 1'b1;
                end
            end
            if (!found)
                status_calc = sfdp_pkg::STATUS_NO_ERASE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg   <= '0;
            first_word_reg   <= '0;
            density_word_reg <= '0;
            erase_low_reg    <= '0;
            erase_high_reg   <= '0;
            page_word_reg    <= '0;
        end
        else
        begin
            word_count_reg   <= word_count_next;
            first_word_reg   <= first_word_next;
            density_word_reg <= density_word_next;
            erase_low_reg    <= erase_low_next;
            erase_high_reg   <= erase_high_next;
            page_word_reg    <= page_word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            cap_reg    <= cap_calc;
            page_reg   <= page_calc;
            esz_reg    <= esz_calc;
            eop_reg    <= eop_calc;
            status_reg <= status_calc;
        end
    end

    assign capacity_bytes  = cap_reg;
    assign page_size_log2  = page_reg;
    assign erase_size_log2 = esz_reg;
    assign erase_opcode    = eop_reg;
    assign decode_status   = status_reg;

endmodule

FILE: rtl/sfdp_controller.sv
// handshake control: word capture, decode step and output valid
module sfdp_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               last_word,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output sfdp_pkg::dp_cmd_t  cmd
);

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_DECODE  = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic word_take;
    logic out_free;

    assign in_ready  = (state_reg == ST_COLLECT);
    assign word_take = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.capture     = word_take;
        cmd.load_result = (state_reg == ST_DECODE) && out_free;
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (word_take && last_word)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                // wait for the result register to drain before loading
                if (out_free)
                begin
                    state_next     = ST_COLLECT;
                    out_valid_next = 1'b1;
                end
            end
            default:
                state_next = ST_COLLECT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_last_goes_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_word) |=> (state_reg == ST_DECODE))
        else $error("last word did not start decode");

    a_decode_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DECODE) && (!out_valid || out_ready))
            |=> (out_valid && (state_reg == ST_COLLECT)))
        else $error("decode did not present a result");

    a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result dropped without handshake");

    a_mid_word_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !last_word) |=> (state_reg == ST_COLLECT))
        else $error("non-final word left collect state");

endmodule

FILE: rtl/sfdp_basic_table_decoder_top.sv
// top level of the sfdp basic parameter table decoder
//
// input channel: one 32-bit table word per handshake (in_valid/in_ready),
// last_word marks the final word of a table. words 0, 1, 7, 8 and 10 are
// kept; words past the sixteenth are dropped but a last mark on them counts.
// output channel: one result per table (out_valid/out_ready) with capacity,
// page size, smallest erase size and opcode, and a status code.
// a non-final word leaves in_ready high for the next word; the final word is
// followed by the decode step, which waits until the result register is free,
// then loads it and raises out_valid.
// while a result waits in the output register the next table's words are
// still taken; only the next decode step stalls until the result is taken,
// and in_ready is low during that step.
// reset: word store cleared, no result pending, input ready.
module sfdp_basic_table_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] table_word,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] capacity_bytes,
    output logic [3:0]  page_size_log2,
    output logic [7:0]  erase_size_log2,
    output logic [7:0]  erase_opcode,
    output logic [1:0]  decode_status
);

    sfdp_pkg::dp_cmd_t cmd;

    sfdp_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_word (last_word),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sfdp_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .table_word      (table_word),
        .cmd             (cmd),
        .capacity_bytes  (capacity_bytes),
        .page_size_log2  (page_size_log2),
        .erase_size_log2 (erase_size_log2),
        .erase_opcode    (erase_opcode),
        .decode_status   (decode_status)
    );

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the sfdp basic parameter table decoder
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_TARGET   = 950;
    localparam int IDLE_PERCENT  = 7;
    localparam int CALM_FROM     = 400;
    localparam int CALM_TO       = 550;
    localparam int HOLD_AT       = 250;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_AT      = 600;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;

    typedef struct {
        logic [31:0] word;
        logic        last;
        logic        drain_first;  // sender waits for every result before offering this word
    } table_item_t;

    typedef struct {
        logic [23:0] capacity;
        logic [3:0]  page_log2;
        logic [7:0]  erase_log2;
        logic [7:0]  opcode;
        logic [1:0]  status;
    } table_decode_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [31:0] table_word = '0;
    logic        last_word  = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [23:0] capacity_bytes;
    logic [3:0]  page_size_log2;
    logic [7:0]  erase_size_log2;
    logic [7:0]  erase_opcode;
    logic [1:0]  decode_status;

    table_item_t   pending_words[$];
    table_decode_t decodes_due[$];

    int words_taken = 0;
    int mismatches  = 0;
    int idle_cycles = 0;
    int hold_left   = 0;
    logic held_once = 1'b0;
    logic calm;

    // shadow copy of the words the block keeps
    sfdp_pkg::count_t kept_count = '0;
    logic [31:0] kept_first    = '0;
    logic [31:0] kept_density  = '0;
    logic [31:0] kept_erase_lo = '0;
    logic [31:0] kept_erase_hi = '0;
    logic [31:0] kept_page     = '0;

    sfdp_basic_table_decoder_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .table_word      (table_word),
        .last_word       (last_word),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .capacity_bytes  (capacity_bytes),
        .page_size_log2  (page_size_log2),
        .erase_size_log2 (erase_size_log2),
        .erase_opcode    (erase_opcode),
        .decode_status   (decode_status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    assign calm = (words_taken >= CALM_FROM) && (words_taken < CALM_TO);

    function automatic logic [23:0] density_to_bytes(logic [31:0] density);
        logic [30:0] n;
        logic [31:0] bit_total;
        n = density[30:0];
        if (density[31])
        begin
            if (n < 3)
                return '0;
            if (n - 3 >= 24)
                return sfdp_pkg::CAP_MAX;
            return 24'(1) << (n - 3);
        end
        bit_total = {1'b0, n} + 32'd1;
        bit_total = bit_total >> 3;
        if (bit_total > {8'h00, sfdp_pkg::CAP_MAX})
            return sfdp_pkg::CAP_MAX;
        return bit_total[23:0];
    endfunction

    function automatic void absorb_word(logic [31:0] w, logic last);
        table_decode_t    r;
        logic [3:0][15:0] entries;
        logic             found;
        if (kept_count < sfdp_pkg::MAX_WORDS)
        begin
            case (int'(kept_count))
                sfdp_pkg::IDX_FIRST:   kept_first    = w;
                sfdp_pkg::IDX_DENSITY: kept_density  = w;
                sfdp_pkg::IDX_ERASE_L: kept_erase_lo = w;
                sfdp_pkg::IDX_ERASE_H: kept_erase_hi = w;
                sfdp_pkg::IDX_PAGE:    kept_page     = w;
                default: ;
            endcase
            kept_count++;
        end
        if (!last)
            return;

        r.capacity   = density_to_bytes(kept_density);
        r.erase_log2 = '0;
        r.opcode     = '0;
        r.status     = sfdp_pkg::STATUS_OK;
        if (kept_count >= sfdp_pkg::LEN_PAGE_WORD)
            r.page_log2 = kept_page[7:4];
        else
            r.page_log2 = kept_first[2] ? sfdp_pkg::PAGE_LOG2_64 : sfdp_pkg::PAGE_LOG2_1;

        if (kept_count < sfdp_pkg::LEN_ERASE_TABLE)
        begin
            if (kept_first[1:0] == sfdp_pkg::LEGACY_4K_OK)
            begin
                r.erase_log2 = sfdp_pkg::LEGACY_ERASE;
                r.opcode     = kept_first[15:8];
            end
            else
                r.status = sfdp_pkg::STATUS_NO_4K;
        end
        else
        begin
            // scan order: word 7 high half first, word 8 low half last
            entries = {kept_erase_lo, kept_erase_hi};
            found   = 1'b0;
            for (int i = 3; i >= 0; i--)
            begin
                if (entries[i][7:0] != 8'h00 && (!found || entries[i][7:0] < r.erase_log2))
                begin
                    r.erase_log2 = entries[i][7:0];
                    r.opcode     = entries[i][15:8];
                    found        = 1'b1;
                end
            end
            if (!found)
                r.status = sfdp_pkg::STATUS_NO_ERASE;
        end
        decodes_due.push_back(r);

        kept_count    = '0;
        kept_first    = '0;
        kept_density  = '0;
        kept_erase_lo = '0;
        kept_erase_hi = '0;
        kept_page     = '0;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void add_word(logic [31:0] w, logic last, logic drain_first);
        table_item_t item;
        item.word        = w;
        item.last        = last;
        item.drain_first = drain_first;
        pending_words.push_back(item);
    endfunction

    function automatic logic [15:0] random_erase_entry();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            return 16'h0000;
        if (pick < 30)
            return {8'($urandom), 8'h00};
        if (pick < 85)
            return {8'($urandom), 8'($urandom_range(24, 1))};
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] random_table_word(int idx, logic no_erase);
        logic [31:0] w;
        w = $urandom();
        case (idx)
            sfdp_pkg::IDX_FIRST:
                if ($urandom_range(1))
                    w[1:0] = sfdp_pkg::LEGACY_4K_OK;
            sfdp_pkg::IDX_DENSITY:
                case ($urandom_range(3))
                    0: w = {1'b1, 31'($urandom_range(40))};
                    1: w = $urandom_range(32'h0800_0000);
                    2: w[31] = 1'b0;
                    default: ;
                endcase
            sfdp_pkg::IDX_ERASE_L, sfdp_pkg::IDX_ERASE_H:
                w = no_erase ? 32'h0 : {random_erase_entry(), random_erase_entry()};
            default: ;
        endcase
        return w;
    endfunction

    function automatic void add_random_table(logic drain_first);
        int   pick;
        int   len;
        logic no_erase;
        pick = $urandom_range(99);
        if (pick < 15)
            len = $urandom_range(8, 1);
        else if (pick < 35)
            len = $urandom_range(10, 9);
        else if (pick < 85)
            len = $urandom_range(16, 11);
        else
            len = $urandom_range(24, 17);
        no_erase = ($urandom_range(99) < 10);
        for (int i = 0; i < len; i++)
            add_word(random_table_word(i, no_erase), i == len - 1, drain_first && i == 0);
    endfunction

    initial
    begin : run_tables
        int   total;
        logic drain_placed;

        // one-word table: the other kept words read as zero
        add_word(32'h0000_2005, 1'b1, 1'b0);
        add_word(32'hffff_ffff, 1'b1, 1'b0);
        // legacy table without 4k erase, tiny exponent density
        add_word(32'h0000_00fa, 1'b0, 1'b0);
        add_word(32'h8000_0002, 1'b1, 1'b0);
        // plain density far above the 24-bit range
        add_word(32'h0000_0000, 1'b0, 1'b0);
        add_word(32'h7fff_ffff, 1'b1, 1'b0);
        // full table with a tie between erase entries and a last mark past the stored range
        for (int i = 0; i < 17; i++)
        begin
            case (i)
                sfdp_pkg::IDX_FIRST:   add_word(32'h0000_0000, 1'b0, 1'b0);
                sfdp_pkg::IDX_DENSITY: add_word(32'h8000_001a, 1'b0, 1'b0);
                sfdp_pkg::IDX_ERASE_L: add_word(32'h200c_d810, 1'b0, 1'b0);
                sfdp_pkg::IDX_ERASE_H: add_word(32'h520c_0000, 1'b0, 1'b0);
                sfdp_pkg::IDX_PAGE:    add_word(32'h0000_0080, 1'b0, 1'b0);
                default:     add_word(i[0] ? 32'hffff_ffff : 32'h0, i == 16, 1'b0);
            endcase
        end

        drain_placed = 1'b0;
        while (pending_words.size() < WORD_TARGET)
        begin
            add_random_table(!drain_placed && pending_words.size() >= DRAIN_AT);
            if (pending_words.size() >= DRAIN_AT)
                drain_placed = 1'b1;
        end
        total = pending_words.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (words_taken != total)
            @(posedge clk);
        while (decodes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    always @(posedge clk)
    begin : drive_words
        logic sender_idle;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                absorb_word(table_word, last_word);
                words_taken <= words_taken + 1;
            end
            if (!in_valid || in_ready)
            begin
                sender_idle = !calm && ($urandom_range(99) < IDLE_PERCENT);
                if (pending_words.size() == 0 || sender_idle
                    || (pending_words[0].drain_first && decodes_due.size() != 0))
                    in_valid <= 1'b0;
                else
                begin
                    in_valid   <= 1'b1;
                    table_word <= pending_words[0].word;
                    last_word  <= pending_words[0].last;
                    void'(pending_words.pop_front());
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        table_decode_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (decodes_due.size() == 0)
                begin
                    $error("result with no table outstanding");
                    mismatches++;
                end
                else
                begin
                    want = decodes_due.pop_front();
                    check_field("capacity_bytes", 32'(want.capacity), 32'(capacity_bytes));
                    check_field("page_size_log2", 32'(want.page_log2), 32'(page_size_log2));
                    check_field("erase_size_log2", 32'(want.erase_log2),
                                32'(erase_size_log2));
                    check_field("erase_opcode", 32'(want.opcode), 32'(erase_opcode));
                    check_field("decode_status", 32'(want.status), 32'(decode_status));
                end
            end

            // one long hold-off so the next decode backs up into the input
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!held_once && words_taken >= HOLD_AT)
            begin
                held_once <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

FILE: sfdp_basic_table_decoder_top.f
rtl/sfdp_pkg.sv
rtl/sfdp_datapath.sv
rtl/sfdp_controller.sv
rtl/sfdp_basic_table_decoder_top.sv
tb/testbench.sv
